// File: hw/rtl/qtf_pkg.sv
// ----------------------------------------------------------------------------
// qtf_pkg : shared types, constants and micro-program for the three point fit
// Holds the transaction structs, the controller/datapath command and status
// structs, the register file map and the fixed micro-program.
// ----------------------------------------------------------------------------
`default_nettype none

package qtf_pkg;

  // Blend steps between the middle ordinate and the chord
  localparam int BLEND_STEPS = 20;
  localparam int K_W         = $clog2(BLEND_STEPS + 1);

  localparam int PT_W   = 16;   // Q8.8 point coordinate
  localparam int COEF_W = 48;   // Q24.24 coefficient
  localparam int ACC_W  = 64;   // register file word
  localparam int MUL_W  = 36;   // multiplier operand width
  localparam int DQ_W   = 50;   // divider quotient / divisor magnitude width
  localparam int DN_W   = 96;   // shifted dividend width
  localparam int SH_W   = 6;    // dividend shift amount width

  // Register file map
  localparam int NREG  = 25;
  localparam int REG_W = 5;
  typedef logic [REG_W-1:0] reg_t;

  localparam reg_t R_X0    = 5'd0;
  localparam reg_t R_Y0    = 5'd1;
  localparam reg_t R_X1    = 5'd2;
  localparam reg_t R_Y1    = 5'd3;
  localparam reg_t R_X2    = 5'd4;
  localparam reg_t R_Y2    = 5'd5;
  localparam reg_t R_YM    = 5'd6;
  localparam reg_t R_S     = 5'd7;
  localparam reg_t R_T0    = 5'd8;
  localparam reg_t R_T1    = 5'd9;
  localparam reg_t R_T2    = 5'd10;
  localparam reg_t R_T3    = 5'd11;
  localparam reg_t R_T4    = 5'd12;
  localparam reg_t R_T5    = 5'd13;
  localparam reg_t R_T6    = 5'd14;
  localparam reg_t R_NA    = 5'd15;
  localparam reg_t R_NB    = 5'd16;
  localparam reg_t R_NC    = 5'd17;
  localparam reg_t R_D     = 5'd18;
  localparam reg_t R_E     = 5'd19;
  localparam reg_t R_W     = 5'd20;
  localparam reg_t R_CH    = 5'd21;
  localparam reg_t R_STEPV = 5'd22;
  localparam reg_t R_NUM   = 5'd23;
  localparam reg_t R_SW    = 5'd24;

  // Micro-operations
  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_CHK,
    OP_DIV
  } op_t;

  // Destination of a division result
  typedef enum logic [1:0] {
    DK_YM,
    DK_QUAD,
    DK_LIN,
    DK_CONST
  } div_kind_t;

  typedef struct packed {
    op_t       op;
    reg_t      rd;
    reg_t      ra;
    reg_t      rb;
    div_kind_t dk;
  } instr_t;

  // Program counter and segment boundaries
  localparam int PC_W = 6;
  typedef logic [PC_W-1:0] pc_t;
  localparam pc_t PC_FIT      = 6'd0;
  localparam pc_t PC_CHK      = 6'd42;
  localparam pc_t PC_SETUP    = 6'd43;
  localparam pc_t PC_STEP     = 6'd53;
  localparam pc_t PC_STEP_END = 6'd54;
  localparam pc_t PC_COEF     = 6'd55;
  localparam pc_t PC_LAST     = 6'd57;

  // Transaction payloads
  typedef struct packed {
    logic                   opcode;
    logic signed [PT_W-1:0] point1_x;
    logic signed [PT_W-1:0] point1_y;
    logic signed [PT_W-1:0] point2_x;
    logic signed [PT_W-1:0] point2_y;
    logic signed [PT_W-1:0] point3_x;
    logic signed [PT_W-1:0] point3_y;
  } fit_in_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_quad;
    logic signed [COEF_W-1:0] coef_lin;
    logic signed [COEF_W-1:0] coef_const;
    logic                     solved;
    logic                     saturated;
  } fit_out_t;

  // Controller to datapath
  typedef struct packed {
    logic       accept;
    logic       sort_en;
    logic [1:0] sort_stage;
    logic       load_en;
    logic [2:0] load_idx;
    logic       issue;
    logic       exec;
    logic       strobe;
    instr_t     instr;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic opcode;
    logic ok;
    logic mono;
    logic pass;
    logic div_done;
  } dp_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SORT,
    ST_LOAD,
    ST_ISSUE,
    ST_EXEC,
    ST_WAITDIV,
    ST_DECIDE,
    ST_DONE
  } ctl_state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_RUN,
    DV_FIN
  } div_state_t;

  function automatic instr_t mk(op_t op, reg_t rd, reg_t ra, reg_t rb, div_kind_t dk);
    instr_t i;
    i.op = op;
    i.rd = rd;
    i.ra = ra;
    i.rb = rb;
    i.dk = dk;
    return i;
  endfunction

  // Micro-program: fit numerators and determinant, slope check, blend set-up,
  // blend step, coefficient divisions
  function automatic instr_t prog(pc_t pc);
    instr_t i;
    unique case (pc)
      // determinant
      6'd0:  i = mk(OP_SUB, R_T0, R_X0, R_X1, DK_YM);
      6'd1:  i = mk(OP_SUB, R_T1, R_X0, R_X2, DK_YM);
      6'd2:  i = mk(OP_SUB, R_T2, R_X1, R_X2, DK_YM);
      6'd3:  i = mk(OP_MUL, R_T0, R_T0, R_T1, DK_YM);
      6'd4:  i = mk(OP_MUL, R_D,  R_T0, R_T2, DK_YM);
      // numerator of a
      6'd5:  i = mk(OP_SUB, R_T0, R_YM, R_Y0, DK_YM);
      6'd6:  i = mk(OP_MUL, R_T0, R_X2, R_T0, DK_YM);
      6'd7:  i = mk(OP_SUB, R_T1, R_Y0, R_Y2, DK_YM);
      6'd8:  i = mk(OP_MUL, R_T1, R_X1, R_T1, DK_YM);
      6'd9:  i = mk(OP_SUB, R_T2, R_Y2, R_YM, DK_YM);
      6'd10: i = mk(OP_MUL, R_T2, R_X0, R_T2, DK_YM);
      6'd11: i = mk(OP_ADD, R_NA, R_T0, R_T1, DK_YM);
      6'd12: i = mk(OP_ADD, R_NA, R_NA, R_T2, DK_YM);
      // squares and numerator of b
      6'd13: i = mk(OP_MUL, R_T3, R_X0, R_X0, DK_YM);
      6'd14: i = mk(OP_MUL, R_T4, R_X1, R_X1, DK_YM);
      6'd15: i = mk(OP_MUL, R_T5, R_X2, R_X2, DK_YM);
      6'd16: i = mk(OP_SUB, R_T0, R_Y0, R_YM, DK_YM);
      6'd17: i = mk(OP_MUL, R_T0, R_T5, R_T0, DK_YM);
      6'd18: i = mk(OP_SUB, R_T1, R_YM, R_Y2, DK_YM);
      6'd19: i = mk(OP_MUL, R_T1, R_T3, R_T1, DK_YM);
      6'd20: i = mk(OP_SUB, R_T2, R_Y2, R_Y0, DK_YM);
      6'd21: i = mk(OP_MUL, R_T2, R_T4, R_T2, DK_YM);
      6'd22: i = mk(OP_ADD, R_NB, R_T0, R_T1, DK_YM);
      6'd23: i = mk(OP_ADD, R_NB, R_NB, R_T2, DK_YM);
      // numerator of c
      6'd24: i = mk(OP_SUB, R_T0, R_X2, R_X0, DK_YM);
      6'd25: i = mk(OP_MUL, R_T0, R_T0, R_YM, DK_YM);
      6'd26: i = mk(OP_MUL, R_T1, R_X0, R_X2, DK_YM);
      6'd27: i = mk(OP_MUL, R_T0, R_T1, R_T0, DK_YM);
      6'd28: i = mk(OP_MUL, R_T1, R_X2, R_Y0, DK_YM);
      6'd29: i = mk(OP_MUL, R_T2, R_X0, R_Y2, DK_YM);
      6'd30: i = mk(OP_SUB, R_T1, R_T1, R_T2, DK_YM);
      6'd31: i = mk(OP_MUL, R_T1, R_T4, R_T1, DK_YM);
      6'd32: i = mk(OP_MUL, R_T2, R_X1, R_Y2, DK_YM);
      6'd33: i = mk(OP_MUL, R_T2, R_T3, R_T2, DK_YM);
      6'd34: i = mk(OP_MUL, R_T6, R_X1, R_Y0, DK_YM);
      6'd35: i = mk(OP_MUL, R_T6, R_T5, R_T6, DK_YM);
      6'd36: i = mk(OP_SUB, R_T2, R_T2, R_T6, DK_YM);
      6'd37: i = mk(OP_ADD, R_NC, R_T0, R_T1, DK_YM);
      6'd38: i = mk(OP_ADD, R_NC, R_NC, R_T2, DK_YM);
      // slope numerator 2*na*x0 + nb, then check
      6'd39: i = mk(OP_ADD, R_E,  R_NA, R_NA, DK_YM);
      6'd40: i = mk(OP_MUL, R_E,  R_E,  R_X0, DK_YM);
      6'd41: i = mk(OP_ADD, R_E,  R_E,  R_NB, DK_YM);
      6'd42: i = mk(OP_CHK, R_E,  R_E,  R_D,  DK_YM);
      // blend set-up
      6'd43: i = mk(OP_SUB, R_W,     R_X2, R_X0,  DK_YM);
      6'd44: i = mk(OP_SUB, R_T0,    R_Y2, R_Y0,  DK_YM);
      6'd45: i = mk(OP_SUB, R_T1,    R_X1, R_X0,  DK_YM);
      6'd46: i = mk(OP_MUL, R_T0,    R_T0, R_T1,  DK_YM);
      6'd47: i = mk(OP_MUL, R_T1,    R_Y0, R_W,   DK_YM);
      6'd48: i = mk(OP_ADD, R_CH,    R_T1, R_T0,  DK_YM);
      6'd49: i = mk(OP_MUL, R_T2,    R_Y1, R_W,   DK_YM);
      6'd50: i = mk(OP_SUB, R_STEPV, R_CH, R_T2,  DK_YM);
      6'd51: i = mk(OP_MUL, R_NUM,   R_S,  R_T2,  DK_YM);
      6'd52: i = mk(OP_MUL, R_SW,    R_S,  R_W,   DK_YM);
      // blend step
      6'd53: i = mk(OP_ADD, R_NUM, R_NUM, R_STEPV, DK_YM);
      6'd54: i = mk(OP_DIV, R_YM,  R_NUM, R_SW,    DK_YM);
      // coefficients
      6'd55: i = mk(OP_DIV, R_T6, R_NA, R_D, DK_QUAD);
      6'd56: i = mk(OP_DIV, R_T6, R_NB, R_D, DK_LIN);
      6'd57: i = mk(OP_DIV, R_T6, R_NC, R_D, DK_CONST);
      default: i = mk(OP_ADD, R_T6, R_T6, R_T6, DK_YM);
    endcase
    return i;
  endfunction

  // Dividend scaling per division kind
  function automatic logic [SH_W-1:0] div_shift(div_kind_t dk);
    logic [SH_W-1:0] s;
    unique case (dk)
      DK_YM:    s = 6'd0;
      DK_QUAD:  s = 6'd32;
      DK_LIN:   s = 6'd24;
      DK_CONST: s = 6'd16;
      default:  s = 6'd0;
    endcase
    return s;
  endfunction

  // Register written at each load cycle
  function automatic reg_t load_addr(logic [2:0] idx);
    reg_t a;
    unique case (idx)
      3'd0:    a = R_X0;
      3'd1:    a = R_Y0;
      3'd2:    a = R_X1;
      3'd3:    a = R_Y1;
      3'd4:    a = R_X2;
      3'd5:    a = R_Y2;
      3'd6:    a = R_YM;
      default: a = R_S;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/qtf_div.sv
// ----------------------------------------------------------------------------
// qtf_div : rounded scaled divider
// Restoring division, one quotient bit a cycle, of |n| * 2^shift by |d| with
// round to nearest (ties away from zero) and clamp to the 48-bit range.
// ----------------------------------------------------------------------------
`default_nettype none

module qtf_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [qtf_pkg::ACC_W-1:0]  num,
  input  wire logic signed [qtf_pkg::ACC_W-1:0]  den,
  input  wire logic [qtf_pkg::SH_W-1:0]          shift,
  output logic                                   done,
  output logic signed [qtf_pkg::COEF_W-1:0]      quot,
  output logic                                   sat
);
  import qtf_pkg::*;

  localparam int CNT_W = $clog2(DQ_W);
  localparam int HI_W  = DN_W - DQ_W;

  div_state_t          st;
  logic [CNT_W-1:0]    cnt;
  logic [DQ_W-1:0]     nlow;
  logic [DQ_W-1:0]     r;
  logic [DQ_W-1:0]     q;
  logic [DQ_W-1:0]     dm;
  logic                neg;
  logic                ovf;

  logic [ACC_W-1:0]    mag_n;
  logic [ACC_W-1:0]    mag_d;
  logic [DN_W-1:0]     ext;
  logic [HI_W-1:0]     hi;
  logic [DQ_W:0]       rs;
  logic                rnd;
  logic [DQ_W:0]       qf;
  logic [DQ_W:0]       lim;
  logic                fsat;
  logic [DQ_W:0]       mag;

  // operand set-up
  always_comb begin
    mag_n = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
    mag_d = den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);
    ext   = {{(DN_W-ACC_W){1'b0}}, mag_n} << shift;
    hi    = ext[DN_W-1:DQ_W];
    rs    = {r, nlow[DQ_W-1]};
  end

  // rounding and clamp
  always_comb begin
    rnd  = {r, 1'b0} >= {1'b0, dm};
    qf   = {1'b0, q} + (DQ_W+1)'(rnd);
    lim  = neg ? ((DQ_W+1)'(1) << (COEF_W-1)) : (((DQ_W+1)'(1) << (COEF_W-1)) - 1'b1);
    fsat = ovf | (qf > lim);
    mag  = fsat ? lim : qf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= DV_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        DV_IDLE: begin
          if (start) begin
            neg  <= num[ACC_W-1] ^ den[ACC_W-1];
            dm   <= mag_d[DQ_W-1:0];
            ovf  <= {{(DQ_W-HI_W){1'b0}}, hi} >= mag_d[DQ_W-1:0];
            r    <= {{(DQ_W-HI_W){1'b0}}, hi};
            nlow <= ext[DQ_W-1:0];
            q    <= '0;
            cnt  <= CNT_W'(DQ_W - 1);
            st   <= DV_RUN;
          end
        end
        DV_RUN: begin
          if (rs >= {1'b0, dm}) begin
            r <= DQ_W'(rs - {1'b0, dm});
            q <= {q[DQ_W-2:0], 1'b1};
          end else begin
            r <= rs[DQ_W-1:0];
            q <= {q[DQ_W-2:0], 1'b0};
          end
          nlow <= {nlow[DQ_W-2:0], 1'b0};
          if (cnt == '0) begin
            st <= DV_FIN;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        DV_FIN: begin
          quot <= neg ? COEF_W'(-mag[COEF_W-1:0]) : mag[COEF_W-1:0];
          sat  <= fsat;
          done <= 1'b1;
          st   <= DV_IDLE;
        end
        default: st <= DV_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/qtf_datapath.sv
// ----------------------------------------------------------------------------
// qtf_datapath : point registers, register file, ALU, multiplier and divider
// Executes the micro-operations the controller issues and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module qtf_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire qtf_pkg::ctl_cmd_t   cmd,
  input  wire qtf_pkg::fit_in_t    item,
  output qtf_pkg::dp_stat_t        stat,
  output qtf_pkg::fit_out_t        result,
  output logic                     done
);
  import qtf_pkg::*;

  logic                     opc;
  logic signed [PT_W-1:0]   px0, px1, px2;
  logic signed [PT_W-1:0]   py0, py1, py2;
  logic signed [ACC_W-1:0]  mem [NREG];
  logic signed [ACC_W-1:0]  rda, rdb;
  logic                     e_zero, e_pos, d_pos, ok;
  fit_out_t                 res;

  logic                     we;
  reg_t                     wa;
  logic signed [ACC_W-1:0]  wd;
  logic signed [2*MUL_W-1:0] prod;
  logic                     swap;
  logic                     inc, dec;

  logic                     div_start;
  logic                     div_done;
  logic signed [COEF_W-1:0] div_quot;
  logic                     div_sat;

  // compare for the current sort stage
  always_comb begin
    if (cmd.sort_stage == 2'd1) begin
      swap = px1 > px2;
    end else begin
      swap = px0 > px1;
    end
  end

  // multiplier and register file write port
  always_comb begin
    prod = $signed(rda[MUL_W-1:0]) * $signed(rdb[MUL_W-1:0]);
    we   = 1'b0;
    wa   = cmd.instr.rd;
    wd   = '0;
    if (cmd.load_en) begin
      we = 1'b1;
      wa = load_addr(cmd.load_idx);
      unique case (cmd.load_idx)
        3'd0:    wd = ACC_W'(px0);
        3'd1:    wd = ACC_W'(py0);
        3'd2:    wd = ACC_W'(px1);
        3'd3:    wd = ACC_W'(py1);
        3'd4:    wd = ACC_W'(px2);
        3'd5:    wd = ACC_W'(py2);
        3'd6:    wd = ACC_W'(py1);
        default: wd = ACC_W'(BLEND_STEPS);
      endcase
    end else if (cmd.exec) begin
      case (cmd.instr.op)
        OP_ADD: begin
          we = 1'b1;
          wd = rda + rdb;
        end
        OP_SUB: begin
          we = 1'b1;
          wd = rda - rdb;
        end
        OP_MUL: begin
          we = 1'b1;
          wd = prod[ACC_W-1:0];
        end
        default: we = 1'b0;
      endcase
    end else if (div_done && cmd.instr.dk == DK_YM) begin
      we = 1'b1;
      wa = R_YM;
      wd = ACC_W'(div_quot);
    end
  end

  // register file with registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd.issue) begin
      rda <= mem[cmd.instr.ra];
      rdb <= mem[cmd.instr.rb];
    end
  end

  // points, flags and result
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.strobe;
      if (cmd.accept) begin
        opc <= item.opcode;
        px0 <= item.point1_x;
        py0 <= item.point1_y;
        px1 <= item.point2_x;
        py1 <= item.point2_y;
        px2 <= item.point3_x;
        py2 <= item.point3_y;
        res <= '0;
      end
      if (cmd.sort_en && opc && swap) begin
        if (cmd.sort_stage == 2'd1) begin
          px1 <= px2;
          px2 <= px1;
          py1 <= py2;
          py2 <= py1;
        end else begin
          px0 <= px1;
          px1 <= px0;
          py0 <= py1;
          py1 <= py0;
        end
      end
      if (cmd.exec && cmd.instr.op == OP_CHK) begin
        e_zero     <= rda == '0;
        e_pos      <= rda > 0;
        d_pos      <= rdb > 0;
        ok         <= rdb != '0;
        res.solved <= rdb != '0;
      end
      if (div_done) begin
        case (cmd.instr.dk)
          DK_QUAD: begin
            res.coef_quad <= div_quot;
            res.saturated <= res.saturated | div_sat;
          end
          DK_LIN: begin
            res.coef_lin  <= div_quot;
            res.saturated <= res.saturated | div_sat;
          end
          DK_CONST: begin
            res.coef_const <= div_quot;
            res.saturated  <= res.saturated | div_sat;
          end
          default: ;
        endcase
      end
    end
  end

  assign div_start = cmd.exec && (cmd.instr.op == OP_DIV);

  qtf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (rda),
    .den   (rdb),
    .shift (div_shift(cmd.instr.dk)),
    .done  (div_done),
    .quot  (div_quot),
    .sat   (div_sat)
  );

  // strictly monotone run of the sorted ordinates
  assign inc = (py0 < py1) && (py1 < py2);
  assign dec = (py0 > py1) && (py1 > py2);

  always_comb begin
    stat.opcode   = opc;
    stat.ok       = ok;
    stat.mono     = inc | dec;
    stat.pass     = e_zero | (inc & (e_pos == d_pos)) | (dec & (e_pos != d_pos));
    stat.div_done = div_done;
  end

  assign result = res;

endmodule

`default_nettype wire

// File: hw/rtl/qtf_ctrl.sv
// ----------------------------------------------------------------------------
// qtf_ctrl : sequencer for the three point fit
// Steps the sort, the register load, the micro-program and the blend loop.
// ----------------------------------------------------------------------------
`default_nettype none

module qtf_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire qtf_pkg::dp_stat_t   stat,
  output qtf_pkg::ctl_cmd_t        cmd,
  output logic                     busy
);
  import qtf_pkg::*;

  ctl_state_t        state, state_next;
  pc_t               pc, pc_next;
  logic [K_W-1:0]    k, k_next;
  logic              setup_done, setup_done_next;
  logic [2:0]        cnt, cnt_next;
  instr_t            instr;

  assign instr = prog(pc);

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pc         <= PC_FIT;
      k          <= '0;
      setup_done <= 1'b0;
      cnt        <= '0;
    end else begin
      state      <= state_next;
      pc         <= pc_next;
      k          <= k_next;
      setup_done <= setup_done_next;
      cnt        <= cnt_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next      = state;
    pc_next         = pc;
    k_next          = k;
    setup_done_next = setup_done;
    cnt_next        = cnt;
    cmd             = '0;
    cmd.instr       = instr;
    cmd.sort_stage  = cnt[1:0];
    cmd.load_idx    = cnt;
    busy            = state != ST_IDLE;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.accept      = 1'b1;
          cnt_next        = '0;
          k_next          = '0;
          setup_done_next = 1'b0;
          state_next      = ST_SORT;
        end
      end
      ST_SORT: begin
        cmd.sort_en = 1'b1;
        if (cnt == 3'd2) begin
          cnt_next   = '0;
          state_next = ST_LOAD;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_LOAD: begin
        cmd.load_en = 1'b1;
        cnt_next    = cnt + 1'b1;
        if (cnt == 3'd7) begin
          pc_next    = PC_FIT;
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd.issue  = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC, ST_WAITDIV: begin
        cmd.exec = state == ST_EXEC;
        if (state == ST_EXEC && instr.op == OP_DIV) begin
          state_next = ST_WAITDIV;
        end else if (state == ST_WAITDIV && !stat.div_done) begin
          state_next = ST_WAITDIV;
        end else if (pc == PC_CHK) begin
          state_next = ST_DECIDE;
        end else if (pc == PC_STEP_END) begin
          pc_next    = PC_FIT;
          state_next = ST_ISSUE;
        end else if (pc == PC_LAST) begin
          state_next = ST_DONE;
        end else begin
          pc_next    = pc + 1'b1;
          state_next = ST_ISSUE;
        end
      end
      ST_DECIDE: begin
        if (!stat.ok) begin
          state_next = ST_DONE;
        end else if (!stat.opcode || !stat.mono || stat.pass ||
                     k == K_W'(BLEND_STEPS)) begin
          pc_next    = PC_COEF;
          state_next = ST_ISSUE;
        end else begin
          k_next          = k + 1'b1;
          pc_next         = setup_done ? PC_STEP : PC_SETUP;
          setup_done_next = 1'b1;
          state_next      = ST_ISSUE;
        end
      end
      ST_DONE: begin
        cmd.strobe = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/quadratic_three_point_fit_top.sv
// Sequence: sort, register load, fit micro-program, then the coefficient
// divisions; each blend step adds an ordinate division plus a full refit.
// One transaction at a time; the result strobe is raised from the done
// state after the last division and registered in the datapath. The fit
// time is set by the issue/execute register file micro-op loop and the
// bit-serial divider. Synchronous reset returns the block to idle.
// ----------------------------------------------------------------------------
// quadratic_three_point_fit_top : parabola through three Q8.8 points
// Controller and datapath; returns Q24.24 coefficients with solve and clamp
// flags, with optional sorting and monotone blending of the middle point.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_three_point_fit_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire qtf_pkg::fit_in_t   item,
  output logic                    busy,
  output logic                    done,
  output qtf_pkg::fit_out_t       result
);
  import qtf_pkg::*;

  ctl_cmd_t  cmd;
  dp_stat_t  stat;

  qtf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  qtf_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .stat   (stat),
    .result (result),
    .done   (done)
  );

endmodule

`default_nettype wire

// File: verif/qtf_checker.sv
// ----------------------------------------------------------------------------
// qtf_checker : result predictor and scoreboard for the three point fit
// Watches accepted transactions on the command and result ports, predicts
// the coefficients and flags of each fit and compares them field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module qtf_checker
  import qtf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire logic     busy,
  input  wire fit_in_t  item,
  input  wire logic     done,
  input  wire fit_out_t result,
  output int            fail_count,
  output int            pending_fits,
  output int            fit_count,
  output int            blend_count
);

  typedef struct {
    logic signed [COEF_W-1:0] q, l, c;
    logic                     ok, sat;
    longint                   na, nb, d;
  } coef_set_t;

  fit_out_t expected_fits[$];

  // round(n * 2^s / d) with ties away from zero, clamped to 48 bits
  function automatic logic signed [COEF_W-1:0] scale_round(
      longint n, int s, longint d, inout logic sat);
    logic signed [191:0] num, den, quo, rem, lim;
    logic                neg;
    neg = (n < 0) != (d < 0);
    num = n < 0 ? -192'(n) : 192'(n);
    den = d < 0 ? -192'(d) : 192'(d);
    num = num << s;
    quo = num / den;
    rem = num % den;
    if (2 * rem >= den) quo = quo + 1;
    lim = neg ? 192'(1) << 47 : (192'(1) << 47) - 1;
    if (quo > lim) begin
      sat = 1'b1;
      quo = lim;
    end
    if (neg) quo = -quo;
    return quo[COEF_W-1:0];
  endfunction

  function automatic coef_set_t solve_fit(longint x1, longint y1, longint x2,
                                          longint y2, longint x3, longint y3);
    coef_set_t f;
    longint    nc;
    f.q = '0; f.l = '0; f.c = '0; f.sat = 1'b0; f.na = 0; f.nb = 0;
    f.d = (x1 - x2) * (x1 - x3) * (x2 - x3);
    f.ok = f.d != 0;
    if (!f.ok) return f;
    f.na = x3 * (y2 - y1) + x2 * (y1 - y3) + x1 * (y3 - y2);
    f.nb = x3 * x3 * (y1 - y2) + x1 * x1 * (y2 - y3) + x2 * x2 * (y3 - y1);
    nc = x1 * x3 * (x3 - x1) * y2 + x2 * x2 * (x3 * y1 - x1 * y3)
       + x2 * (x1 * x1 * y3 - x3 * x3 * y1);
    f.q = scale_round(f.na, 32, f.d, f.sat);
    f.l = scale_round(f.nb, 24, f.d, f.sat);
    f.c = scale_round(nc, 16, f.d, f.sat);
    return f;
  endfunction

  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic fit_out_t predict_fit(fit_in_t it, output bit blended);
    longint    px[3], py[3], t, w, chord, num, ym, slope;
    coef_set_t f;
    bit        inc, dec;
    fit_out_t  r;
    blended = 0;
    px[0] = it.point1_x; py[0] = it.point1_y;
    px[1] = it.point2_x; py[1] = it.point2_y;
    px[2] = it.point3_x; py[2] = it.point3_y;
    if (!it.opcode) begin
      f = solve_fit(px[0], py[0], px[1], py[1], px[2], py[2]);
    end else begin
      // three compare-and-swap stages on x
      for (int s = 0; s < 3; s++) begin
        int a, b;
        a = (s == 1) ? 1 : 0;
        b = a + 1;
        if (px[a] > px[b]) begin
          t = px[a]; px[a] = px[b]; px[b] = t;
          t = py[a]; py[a] = py[b]; py[b] = t;
        end
      end
      f = solve_fit(px[0], py[0], px[1], py[1], px[2], py[2]);
      inc = py[0] < py[1] && py[1] < py[2];
      dec = py[0] > py[1] && py[1] > py[2];
      if (f.ok && (inc || dec)) begin
        blended = 1;
        w = px[2] - px[0];
        chord = py[0] * w + (py[2] - py[0]) * (px[1] - px[0]);
        for (int k = 0; k <= BLEND_STEPS; k++) begin
          num = longint'(BLEND_STEPS - k) * py[1] * w + longint'(k) * chord;
          ym = round_div(num, longint'(BLEND_STEPS) * w);
          f = solve_fit(px[0], py[0], px[1], ym, px[2], py[2]);
          slope = 2 * f.na * px[0] + f.nb;
          if (slope == 0) break;
          if (inc && ((slope > 0) == (f.d > 0))) break;
          if (dec && ((slope > 0) != (f.d > 0))) break;
        end
      end
    end
    r.coef_quad = f.q; r.coef_lin = f.l; r.coef_const = f.c;
    r.solved = f.ok; r.saturated = f.sat;
    return r;
  endfunction

  // Predict on accepted command, compare on result strobe
  always @(posedge clk) begin
    fit_out_t e;
    bit       bl;
    if (rst) begin
      fail_count <= 0; pending_fits <= 0; fit_count <= 0; blend_count <= 0;
    end else begin
      if (start && !busy) begin
        expected_fits.push_back(predict_fit(item, bl));
        if (bl) blend_count <= blend_count + 1;
      end
      if (done) begin
        fit_count <= fit_count + 1;
        if (expected_fits.size() == 0) begin
          $error("unexpected result transaction");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_fits.pop_front();
          if (result !== e) begin
            if (result.coef_quad !== e.coef_quad)
              $error("coef_quad exp %0d got %0d", e.coef_quad, result.coef_quad);
            if (result.coef_lin !== e.coef_lin)
              $error("coef_lin exp %0d got %0d", e.coef_lin, result.coef_lin);
            if (result.coef_const !== e.coef_const)
              $error("coef_const exp %0d got %0d", e.coef_const, result.coef_const);
            if (result.solved !== e.solved)
              $error("solved exp %0b got %0b", e.solved, result.solved);
            if (result.saturated !== e.saturated)
              $error("saturated exp %0b got %0b", e.saturated, result.saturated);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_fits <= expected_fits.size();
    end
  end

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top : stimulus and verdict for the three point fit
// Drives directed corner fits then random plain and monotone fits with
// sender gaps in several phases; the checker does all prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
  import qtf_pkg::*;

  localparam int  N_RANDOM  = 1750;
  localparam longint LIMIT  = 20_000_000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  fit_in_t  item = '0;
  logic     busy, done;
  fit_out_t result;
  int       fail_count, pending_fits, fit_count, blend_count;
  longint   cycle_count = 0;
  int       idle_pct = 0;

  always #5 clk = ~clk;

  quadratic_three_point_fit_top u_top (
    .clk(clk), .rst(rst), .start(start), .item(item),
    .busy(busy), .done(done), .result(result)
  );

  qtf_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .fail_count(fail_count),
    .pending_fits(pending_fits), .fit_count(fit_count), .blend_count(blend_count)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("quadratic_three_point_fit_top test failed");
      $finish;
    end
  end

  // Issue one transaction once the block is free, with an optional random gap
  task automatic send_fit(fit_in_t it);
    @(posedge clk);
    while (busy || (idle_pct != 0 && $urandom_range(99) < idle_pct)) @(posedge clk);
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
  endtask

  function automatic fit_in_t mk_fit(bit op, int x1, int y1, int x2, int y2,
                                     int x3, int y3);
    fit_in_t it;
    it.opcode = op;
    it.point1_x = PT_W'(x1); it.point1_y = PT_W'(y1);
    it.point2_x = PT_W'(x2); it.point2_y = PT_W'(y2);
    it.point3_x = PT_W'(x3); it.point3_y = PT_W'(y3);
    return it;
  endfunction

  // Mostly monotone runs, half of them with small x, some full-range noise
  function automatic fit_in_t rand_fit();
    fit_in_t it;
    int      sel, x0, dx1, dx2, y0, dy1, dy2, sg, span;
    sel = $urandom_range(99);
    if (sel < 20) begin
      it = fit_in_t'({1'($urandom), $urandom, $urandom, $urandom});
    end else begin
      span = (sel < 60) ? 2047 : 32767;
      x0 = $urandom_range(span) - span / 2 - 1;
      dx1 = $urandom_range(1, 1000);
      dx2 = $urandom_range(1, 1000);
      if (sel < 25) dx2 = 0;
      sg = $urandom_range(1) ? 1 : -1;
      y0 = $urandom_range(8191) - 4096;
      dy1 = sg * $urandom_range(0, 4000);
      dy2 = sg * $urandom_range(0, 4000);
      it = mk_fit($urandom_range(99) < 75, x0, y0, x0 + dx1, y0 + dy1,
                  x0 + dx1 + dx2, y0 + dy1 + dy2);
      // shuffle points so sorting gets work
      if ($urandom_range(1)) begin
        {it.point1_x, it.point3_x} = {it.point3_x, it.point1_x};
        {it.point1_y, it.point3_y} = {it.point3_y, it.point1_y};
      end
      if ($urandom_range(1)) begin
        {it.point1_x, it.point2_x} = {it.point2_x, it.point1_x};
        {it.point1_y, it.point2_y} = {it.point2_y, it.point1_y};
      end
    end
    return it;
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners: extremes, coincident x, saturation, monotone runs
    send_fit(mk_fit(1'b0, 0, 0, 256, 256, 512, 1024));
    send_fit(mk_fit(1'b0, -32768, -32768, 0, 32767, 32767, -32768));
    send_fit(mk_fit(1'b0, 32767, 32767, -32768, -32768, 0, 0));
    send_fit(mk_fit(1'b0, 100, 5, 100, 7, 300, 9));
    send_fit(mk_fit(1'b1, 100, 5, 300, 7, 100, 9));
    send_fit(mk_fit(1'b0, 0, 32767, 1, -32768, 2, 32767));
    send_fit(mk_fit(1'b0, -1, -1, -1, -1, -1, -1));
    send_fit(mk_fit(1'b0, 0, 0, 1, 0, 2, 0));
    send_fit(mk_fit(1'b1, 0, 0, 256, 10, 512, 4000));
    send_fit(mk_fit(1'b1, 512, 4000, 0, 0, 256, 10));
    send_fit(mk_fit(1'b1, 0, 4000, 256, 3990, 512, 0));
    send_fit(mk_fit(1'b1, 0, 0, 10, 3000, 512, 3001));
    send_fit(mk_fit(1'b1, 0, 5, 256, 3, 512, 9));
    send_fit(mk_fit(1'b1, -32768, -32768, 0, 0, 32767, 32767));
    send_fit(mk_fit(1'b1, -32768, 32767, 1, 0, 32767, -32768));
    send_fit(mk_fit(1'b1, 0, 0, 1, 1, 3, 2));
    send_fit(mk_fit(1'b1, 0, 0, 256, 256, 512, 512));
    send_fit(mk_fit(1'b1, 300, 1, 200, 2, 100, 3));

    // Hold off until the block has drained
    do @(posedge clk); while (pending_fits != 0 || busy);

    for (int i = 0; i < N_RANDOM; i++) begin
      case ((i * 4) / N_RANDOM)
        0: idle_pct = 0;
        1: idle_pct = 66;
        2: idle_pct = 38;
        default: idle_pct = (i % 200 < 100) ? 0 : 66;
      endcase
      send_fit(rand_fit());
    end

    do @(posedge clk); while (pending_fits != 0 || busy);
    repeat (40) @(posedge clk);
    $display("Checked %0d fits, %0d of them through the monotone blend path",
             fit_count, blend_count);
    if (fail_count == 0 && pending_fits == 0) begin
      $display("quadratic_three_point_fit_top test passed");
    end else begin
      $display("quadratic_three_point_fit_top test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
hw/rtl/qtf_pkg.sv
hw/rtl/qtf_div.sv
hw/rtl/qtf_datapath.sv
hw/rtl/qtf_ctrl.sv
hw/rtl/quadratic_three_point_fit_top.sv
verif/qtf_checker.sv
verif/tb_top.sv
